// File: rtl/core/e2utc_pkg.sv
// Shared constants, stage record types and arithmetic helpers for the epoch-to-UTC core.
package e2utc_pkg;

  // Word widths on the stream ports
  localparam int unsigned IN_W  = 40;
  localparam int unsigned OUT_W = 56;

  // Pipeline depth: calculation stages, then one output register
  localparam int unsigned NSTAGE = 10;

  // Calculation stage indexes
  localparam int unsigned ST_DAYS  = 0;
  localparam int unsigned ST_REM   = 1;
  localparam int unsigned ST_ERA   = 2;
  localparam int unsigned ST_DOE   = 3;
  localparam int unsigned ST_CENT  = 4;
  localparam int unsigned ST_ADJ   = 5;
  localparam int unsigned ST_YOE   = 6;
  localparam int unsigned ST_YDAYS = 7;
  localparam int unsigned ST_DOY   = 8;
  localparam int unsigned ST_MP    = 9;

  // Calendar constants
  localparam logic [9:0]  DAY_DIV_LO    = 10'd675;       // 86400 = 675 * 128
  localparam logic [22:0] EPOCH_SHIFT   = 23'd719468;    // days from 0000-03-01 to 1970-01-01
  localparam logic [17:0] DAYS_PER_ERA  = 18'd146097;    // days in 400 years
  localparam logic [17:0] ERA_LAST_DAY  = 18'd146096;
  localparam logic [17:0] CENT_1        = 18'd36524;
  localparam logic [17:0] CENT_2        = 18'd73048;
  localparam logic [17:0] CENT_3        = 18'd109572;
  localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
  localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
  localparam logic [8:0]  YEARS_PER_ERA = 9'd400;
  localparam logic [14:0] YEAR_BASE     = 15'd1900;
  localparam logic [3:0]  MP_JANUARY    = 4'd10;         // March-based month index of January
  localparam logic [3:0]  MON_FEBRUARY  = 4'd1;

  // Rounded-up reciprocals: floor(x * M >> k) equals floor(x / d) for every x below 2^N
  // when 2^k >= 2^N * d.
  localparam int unsigned DAY_SH  = 42;
  localparam logic [32:0] DAY_M   = 33'(((64'd1 << DAY_SH) + 64'd674) / 64'd675);
  localparam int unsigned ERA_SH  = 41;
  localparam logic [23:0] ERA_M   = 24'(((64'd1 << ERA_SH) + 64'd146096) / 64'd146097);
  localparam int unsigned M60A_SH = 23;
  localparam logic [17:0] M60A    = 18'(((64'd1 << M60A_SH) + 64'd59) / 64'd60);
  localparam int unsigned M60B_SH = 17;
  localparam logic [11:0] M60B    = 12'(((64'd1 << M60B_SH) + 64'd59) / 64'd60);
  localparam int unsigned Q4Y_SH  = 29;
  localparam logic [18:0] Q4Y_M   = 19'(((64'd1 << Q4Y_SH) + 64'd1459) / 64'd1460);
  localparam int unsigned YR_SH   = 27;
  localparam logic [18:0] YR_M    = 19'(((64'd1 << YR_SH) + 64'd364) / 64'd365);
  localparam int unsigned C100_SH = 16;
  localparam logic [9:0]  C100_M  = 10'(((64'd1 << C100_SH) + 64'd99) / 64'd100);
  localparam int unsigned MP_SH   = 19;
  localparam logic [11:0] MP_M    = 12'(((64'd1 << MP_SH) + 64'd152) / 64'd153);

  // Record that travels down the calculation stages
  typedef struct packed {
    logic        neg;
    logic [31:0] x;        // seconds / 128
    logic [6:0]  lo7;      // seconds % 128
    logic [22:0] days;
    logic [22:0] z;
    logic [16:0] rem;      // seconds of the day
    logic [5:0]  era;
    logic [10:0] m60;      // minutes of the day
    logic [5:0]  sec;
    logic [5:0]  min;
    logic [4:0]  hr;
    logic [17:0] doe;      // day of era
    logic [6:0]  q1460;
    logic [2:0]  q36524;
    logic        qlast;
    logic [17:0] t;
    logic [2:0]  wd;
    logic [8:0]  yoe;      // year of era
    logic [17:0] y365;
    logic [1:0]  yq100;
    logic [8:0]  doy;      // March-based day of year
    logic [3:0]  mp;       // March-based month
  } calc_t;

  typedef struct packed {
    logic        valid_res;
    logic [5:0]  second_of_minute;
    logic [5:0]  minute_of_hour;
    logic [4:0]  hour_of_day;
    logic [4:0]  day_of_month;
    logic [3:0]  month_index;
    logic [14:0] years_since_1900;
    logic [2:0]  weekday;
    logic [8:0]  day_of_year;
  } res_t;

  // Residue mod 7 by summing octal digits (8 = 1 mod 7)
  function automatic logic [2:0] mod7(input logic [20:0] v);
    logic [5:0] s1;
    logic [3:0] s2;
    s1 = '0;
    for (int i = 0; i < 7; i++) begin
      s1 = s1 + 6'(v[3*i +: 3]);
    end
    s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
    return (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
  endfunction

  // First day of each March-based month
  function automatic logic [8:0] mp_base(input logic [3:0] mp);
    logic [8:0] b;
    case (mp)
      4'd0:    b = 9'd0;
      4'd1:    b = 9'd31;
      4'd2:    b = 9'd61;
      4'd3:    b = 9'd92;
      4'd4:    b = 9'd122;
      4'd5:    b = 9'd153;
      4'd6:    b = 9'd184;
      4'd7:    b = 9'd214;
      4'd8:    b = 9'd245;
      4'd9:    b = 9'd275;
      4'd10:   b = 9'd306;
      4'd11:   b = 9'd337;
      default: b = 9'd0;
    endcase
    return b;
  endfunction

  // Days before each month of a common year
  function automatic logic [8:0] cum_days(input logic [3:0] mon);
    logic [8:0] d;
    case (mon)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd334;
    endcase
    return d;
  endfunction

  // Work of one calculation stage
  function automatic calc_t calc_step(input int unsigned idx, input calc_t c);
    calc_t       r;
    logic [64:0] p_day;
    logic [32:0] p_lo;
    logic [32:0] d_lo;
    logic [47:0] p_era;
    logic [34:0] p_m60;
    logic [22:0] p_ed;
    logic [22:0] d_ed;
    logic [16:0] d_sec;
    logic [22:0] p_hr;
    logic [36:0] p_q4;
    logic [10:0] d_min;
    logic [36:0] p_yr;
    logic [18:0] p_c100;
    logic [17:0] d_doy;
    logic [10:0] v5;
    logic [22:0] p_mp;
    r = c;
    case (idx)
      ST_DAYS: begin
        p_day  = 65'(c.x) * 65'(DAY_M);
        r.days = p_day[DAY_SH +: 23];
      end
      ST_REM: begin
        p_lo  = 33'(c.days) * 33'(DAY_DIV_LO);
        d_lo  = 33'(c.x) - p_lo;
        r.rem = {d_lo[9:0], c.lo7};
        r.z   = c.days + EPOCH_SHIFT;
      end
      ST_ERA: begin
        p_era = 48'(c.z) * 48'(ERA_M);
        r.era = p_era[ERA_SH +: 6];
        p_m60 = 35'(c.rem) * 35'(M60A);
        r.m60 = p_m60[M60A_SH +: 11];
      end
      ST_DOE: begin
        p_ed  = 23'(c.era) * 23'(DAYS_PER_ERA);
        d_ed  = c.z - p_ed;
        r.doe = d_ed[17:0];
        d_sec = c.rem - 17'(c.m60) * 17'(SECS_PER_MIN);
        r.sec = d_sec[5:0];
        p_hr  = 23'(c.m60) * 23'(M60B);
        r.hr  = p_hr[M60B_SH +: 5];
      end
      ST_CENT: begin
        p_q4     = 37'(c.doe) * 37'(Q4Y_M);
        r.q1460  = p_q4[Q4Y_SH +: 7];
        r.q36524 = 3'(c.doe >= CENT_1) + 3'(c.doe >= CENT_2) + 3'(c.doe >= CENT_3)
                 + 3'(c.doe >= ERA_LAST_DAY);
        r.qlast  = (c.doe == ERA_LAST_DAY);
        d_min    = c.m60 - 11'(c.hr) * 11'(SECS_PER_MIN);
        r.min    = d_min[5:0];
        // weekday: epoch day 0 is Thursday and an era is a whole number of weeks
        r.wd     = mod7(21'(c.doe) + 21'd3);
      end
      ST_ADJ: begin
        r.t = c.doe - 18'(c.q1460) + 18'(c.q36524) - 18'(c.qlast);
      end
      ST_YOE: begin
        p_yr  = 37'(c.t) * 37'(YR_M);
        r.yoe = p_yr[YR_SH +: 9];
      end
      ST_YDAYS: begin
        r.y365  = 18'(c.yoe) * 18'(DAYS_PER_YEAR) + 18'(c.yoe[8:2]);
        p_c100  = 19'(c.yoe) * 19'(C100_M);
        r.yq100 = p_c100[C100_SH +: 2];
      end
      ST_DOY: begin
        d_doy = c.doe - (c.y365 - 18'(c.yq100));
        r.doy = d_doy[8:0];
      end
      ST_MP: begin
        v5   = 11'(c.doy) * 11'd5 + 11'd2;
        p_mp = 23'(v5) * 23'(MP_M);
        r.mp = p_mp[MP_SH +: 4];
      end
      default: begin
        r = c;
      end
    endcase
    return r;
  endfunction

  // Month, day, year and day of year from the last calculation stage
  function automatic res_t calc_finish(input calc_t c);
    res_t        o;
    logic        jf;
    logic [3:0]  mon;
    logic [8:0]  md9;
    logic [8:0]  y400;
    logic        leap;
    logic [14:0] year;
    jf   = (c.mp >= MP_JANUARY);
    mon  = jf ? (c.mp - MP_JANUARY) : (c.mp + 4'd2);
    md9  = c.doy - mp_base(c.mp) + 9'd1;
    // year mod 400 is the year of era, plus one for January and February
    y400 = c.yoe + 9'(jf);
    leap = (y400[1:0] == 2'b00) && (y400 != 9'd100) && (y400 != 9'd200)
        && (y400 != 9'd300);
    year = 15'(c.era) * 15'(YEARS_PER_ERA) + 15'(c.yoe) + 15'(jf);
    o.valid_res        = 1'b1;
    o.second_of_minute = c.sec;
    o.minute_of_hour   = c.min;
    o.hour_of_day      = c.hr;
    o.day_of_month     = md9[4:0];
    o.month_index      = mon;
    o.years_since_1900 = year - YEAR_BASE;
    o.weekday          = c.wd;
    o.day_of_year      = cum_days(mon) + md9 - 9'd1 + 9'(leap && (mon > MON_FEBRUARY));
    if (c.neg) begin
      o = '0;
    end
    return o;
  endfunction

endpackage

// File: rtl/core/epoch_seconds_to_utc_calendar_core.sv
// Top level: pipelined conversion of epoch seconds to a broken-down UTC calendar time.
//
// Usage
//   Slave stream: one 40-bit two's complement count of seconds since
//   1970-01-01 00:00:00 UTC per word. Master stream: one calendar result per
//   input word, in order; tuser carries valid_res, cleared (with all tdata
//   zero) for a negative count.
//   Path: an accepted word passes through ten calculation stages (each
//   about one constant multiply plus an add) and the output register
//   before tvalid rises on the master side.
//   Throughput: one word per cycle when the master side is ready.
//   Stall: every stage carries its own valid bit and holds while the stage
//   after it is full, so bubbles close up; s_axis_tready drops only once all
//   eleven registers hold words and the receiver is not ready. Nothing is
//   lost or repeated.
//   Reset: rst_ni clears all valid bits at once; the block accepts words in
//   the first cycle after reset is released. There is no configuration.
//   Division by constants uses rounded-up reciprocals exact over the
//   operand ranges; the weekday comes from an octal digit sum mod 7.
module epoch_seconds_to_utc_calendar_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // slave stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [e2utc_pkg::IN_W-1:0]    s_axis_tdata,   // [39:0] epoch_seconds
  // master stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [e2utc_pkg::OUT_W-1:0]   m_axis_tdata,   // [5:0] second_of_minute,
                                                        // [11:6] minute_of_hour,
                                                        // [16:12] hour_of_day,
                                                        // [21:17] day_of_month,
                                                        // [25:22] month_index,
                                                        // [40:26] years_since_1900,
                                                        // [43:41] weekday,
                                                        // [52:44] day_of_year,
                                                        // [55:53] zero
  output logic                          m_axis_tuser    // [0] valid_res
);
  import e2utc_pkg::*;

  calc_t             seed;
  calc_t             calc_d [NSTAGE];
  calc_t             calc_q [NSTAGE];
  logic [NSTAGE-1:0] vld_q;
  logic [NSTAGE-1:0] vin;
  logic [NSTAGE-1:0] rdy;
  logic              out_rdy;
  logic              out_vld_q;
  res_t              res_d;
  res_t              res_q;

  // Split the input word: bit 39 is the sign, the rest is seconds / 128 and seconds % 128
  always_comb begin
    seed     = '0;
    seed.neg = s_axis_tdata[IN_W-1];
    seed.x   = s_axis_tdata[IN_W-2:7];
    seed.lo7 = s_axis_tdata[6:0];
  end

  // Next value of each stage from the stage before it
  always_comb begin
    calc_d[0] = calc_step(ST_DAYS, seed);
    for (int k = 1; k < NSTAGE; k++) begin
      calc_d[k] = calc_step(k, calc_q[k-1]);
    end
  end

  assign res_d = calc_finish(calc_q[NSTAGE-1]);

  // Ready ripples back: a stage may load when it is empty or the next one loads
  assign out_rdy = !out_vld_q || m_axis_tready;

  always_comb begin
    rdy[NSTAGE-1] = !vld_q[NSTAGE-1] || out_rdy;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  always_comb begin
    vin[0] = s_axis_tvalid;
    for (int k = 1; k < NSTAGE; k++) begin
      vin[k] = vld_q[k-1];
    end
  end

  assign s_axis_tready = rdy[0];

  // Valid bits: advance when the stage loads, hold otherwise
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      for (int k = 0; k < NSTAGE; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vin[k];
        end
      end
      if (out_rdy) begin
        out_vld_q <= vld_q[NSTAGE-1];
      end
    end
  end

  // Payload registers: load only with a valid word, hold while stalled
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NSTAGE; k++) begin
      if (rdy[k] && vin[k]) begin
        calc_q[k] <= calc_d[k];
      end
    end
    if (out_rdy && vld_q[NSTAGE-1]) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = res_q.valid_res;
  assign m_axis_tdata  = {3'b000,
                          res_q.day_of_year,
                          res_q.weekday,
                          res_q.years_since_1900,
                          res_q.month_index,
                          res_q.day_of_month,
                          res_q.hour_of_day,
                          res_q.minute_of_hour,
                          res_q.second_of_minute};

  // A negative count leaves every calendar field at zero
  a_neg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("negative input produced non-zero fields");

  // Calendar fields stay within their ranges
  a_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |->
      (res_q.second_of_minute < 6'd60) && (res_q.minute_of_hour < 6'd60) &&
      (res_q.hour_of_day < 5'd24) && (res_q.month_index < 4'd12) &&
      (res_q.day_of_month != 5'd0) && (res_q.weekday < 3'd7))
    else $error("calendar field out of range");

  // In January the day of year follows the day of month
  a_january: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser && (res_q.month_index == 4'd0)) |->
      (res_q.day_of_year == 9'(res_q.day_of_month) - 9'd1))
    else $error("day of year disagrees with January date");

  // Back-pressure reaches the input only when the pipeline is full and blocked
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && (&vld_q)))
    else $error("input stalled with room in the pipeline");

endmodule
